// File: src/mgb_pkg.sv
// shared types, register codes and helpers for the clipped glyph blitter
`default_nettype none
package mgb_pkg;

    // clamp limits for frame and glyph sizes
    localparam logic [11:0] MAX_FRAME_DIM = 12'd2048;
    localparam logic [6:0]  MAX_GLYPH_DIM = 7'd64;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLYPH_COLS   = 3'd2;
    localparam logic [2:0] REG_GLYPH_ROWS   = 3'd3;
    localparam logic [2:0] REG_INK_WHITE    = 3'd4;

    // reset values of the registers
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd800;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [6:0]  RST_GLYPH_COLS   = 7'd19;
    localparam logic [6:0]  RST_GLYPH_ROWS   = 7'd25;

    // input item
    typedef struct packed {
        logic [7:0]         glyph_byte;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic               glyph_start;
    } in_t;

    // result item
    typedef struct packed {
        logic [18:0] byte_address;
        logic [7:0]  bit_mask;
        logic        set_bits;
        logic        last_of_run;
    } out_t;

    // configuration register set
    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [6:0]  glyph_cols;
        logic [6:0]  glyph_rows;
        logic        ink_white;
    } cfg_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [10:0] py;
        logic [7:0]  lmask;
        logic [7:0]  rmask;
        logic [10:0] bidx;
    } cmd_t;

    function automatic logic [11:0] clamp_frame(input logic [11:0] v);
        return (v > MAX_FRAME_DIM) ? MAX_FRAME_DIM : v;
    endfunction

    function automatic logic [6:0] clamp_glyph(input logic [6:0] v);
        return (v > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : v;
    endfunction

endpackage
`default_nettype wire

// File: src/mgb_front.sv
// front end: glyph counters, clipping and per-byte mask split
`default_nettype none
module mgb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mgb_pkg::cfg_t cfg,
    input  wire mgb_pkg::in_t  item,
    input  wire logic          accept,
    output mgb_pkg::cmd_t      cmd,
    output logic               cmd_live
);

    logic [5:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [5:0]  row_eff;
    logic [2:0]  col_eff;
    logic [6:0]  cols;
    logic [6:0]  rows;
    logic [11:0] fw;
    logic [11:0] fh;
    logic [3:0]  gstride;
    logic [12:0] py13;
    logic        row_ok;
    logic [13:0] px0;
    logic [7:0]  m;
    logic [15:0] w;

    // effective sizes
    always_comb
    begin
        cols    = mgb_pkg::clamp_glyph(cfg.glyph_cols);
        rows    = mgb_pkg::clamp_glyph(cfg.glyph_rows);
        fw      = mgb_pkg::clamp_frame(cfg.frame_width);
        fh      = mgb_pkg::clamp_frame(cfg.frame_height);
        gstride = 4'(({1'b0, cols} + 8'd7) >> 3);
        if (gstride == 4'd0)
        begin
            gstride = 4'd1;
        end
    end

    // counters as seen by this item
    assign row_eff = item.glyph_start ? 6'd0 : row_reg;
    assign col_eff = item.glyph_start ? 3'd0 : col_reg;

    // vertical clip
    always_comb
    begin
        py13   = {item.origin_y[11], item.origin_y} + {7'd0, row_eff};
        row_ok = ({1'b0, row_eff} < rows) && !py13[12] && (py13[11:0] < fh);
    end

    // horizontal clip per pixel
    always_comb
    begin
        logic [13:0] px;
        logic [5:0]  gc;
        px0 = {{2{item.origin_x[11]}}, item.origin_x} + {8'd0, col_eff, 3'd0};
        m   = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            px = px0 + 14'(i);
            gc = {col_eff, 3'(i)};
            m[7 - i] = item.glyph_byte[7 - i] && ({1'b0, gc} < cols) && !px[13]
                       && (px[12:0] < {1'b0, fw}) && row_ok;
        end
        w = {m, 8'h00} >> px0[2:0];
    end

    // classified item
    always_comb
    begin
        cmd.py    = py13[10:0];
        cmd.lmask = w[15:8];
        cmd.rmask = w[7:0];
        cmd.bidx  = px0[13:3];
        cmd_live  = (m != 8'h00);
    end

    // counter advance
    always_comb
    begin
        row_next = row_eff;
        col_next = col_eff + 3'd1;
        if (({1'b0, col_eff} + 4'd1) >= gstride)
        begin
            col_next = 3'd0;
            if (({1'b0, row_eff} + 7'd1) >= rows)
            begin
                row_next = 6'd0;
            end
            else
            begin
                row_next = row_eff + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 6'd0;
            col_reg <= 3'd0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule
`default_nettype wire

// File: src/mgb_queue.sv
// two-entry queue between front and back
`default_nettype none
module mgb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mgb_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               nonempty,
    output mgb_pkg::cmd_t      head
);

    mgb_pkg::cmd_t mem_reg [2];
    logic          wptr_reg, wptr_next;
    logic          rptr_reg, rptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_pop;

    // status
    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign head     = mem_reg[rptr_reg];
    assign do_pop   = pop && nonempty;

    // pointer and count update
    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: src/mgb_back.sv
// back end: row address multiply and one framebuffer write per cycle while write_stall is low
`default_nettype none
module mgb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mgb_pkg::cfg_t cfg,
    input  wire logic          q_nonempty,
    input  wire mgb_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               write_valid,
    output mgb_pkg::out_t      write_item,
    input  wire logic          write_stall
);

    logic          a_valid_reg, a_valid_next;
    logic [18:0]   a_prod_reg, a_prod_next;
    logic [7:0]    a_lmask_reg, a_lmask_next;
    logic [7:0]    a_rmask_reg;
    logic [10:0]   a_bidx_reg;
    logic          out_valid_reg, out_valid_next;
    mgb_pkg::out_t out_reg, out_next;
    logic [8:0]    fstride;
    logic          out_adv;
    logic          emit_last;
    logic [18:0]   addr_left;

    // row stride in bytes
    assign fstride = 9'((13'(mgb_pkg::clamp_frame(cfg.frame_width)) + 13'd7) >> 3);

    assign out_adv   = !out_valid_reg || !write_stall;
    assign emit_last = (a_lmask_reg == 8'h00) || (a_rmask_reg == 8'h00);
    assign q_pop     = q_nonempty && (!a_valid_reg || (out_adv && emit_last));
    assign addr_left = a_prod_reg + {{8{a_bidx_reg[10]}}, a_bidx_reg};

    // working stage: load, multiply, retire
    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_lmask_next = a_lmask_reg;
        a_prod_next  = 19'(q_head.py) * 19'(fstride);
        if (a_valid_reg && out_adv)
        begin
            if (emit_last)
            begin
                a_valid_next = 1'b0;
            end
            else
            begin
                a_lmask_next = 8'h00;
            end
        end
        if (q_pop)
        begin
            a_valid_next = 1'b1;
            a_lmask_next = q_head.lmask;
        end
    end

    // next write: left byte first, then right byte
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_adv)
        begin
            out_valid_next = a_valid_reg;
            if (a_lmask_reg != 8'h00)
            begin
                out_next.byte_address = addr_left;
                out_next.bit_mask     = a_lmask_reg;
            end
            else
            begin
                out_next.byte_address = addr_left + 19'd1;
                out_next.bit_mask     = a_rmask_reg;
            end
            out_next.set_bits    = cfg.ink_white;
            out_next.last_of_run = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_lmask_reg <= a_lmask_next;
        out_reg     <= out_next;
        if (q_pop)
        begin
            a_prod_reg  <= a_prod_next;
            a_rmask_reg <= q_head.rmask;
            a_bidx_reg  <= q_head.bidx;
        end
    end

    assign write_valid = out_valid_reg;
    assign write_item  = out_reg;

endmodule
`default_nettype wire

// File: src/mono_glyph_blit_clipped_top.sv
// clipped 1bpp glyph blitter: top level with configuration registers
// path: an item's first write is registered in the queue, then the working stage, then the output register
// throughput: one item per cycle when it makes one write or none and writes are not
// stalled; an item with two writes holds the single write stage of the back end for both
// reset: counters at zero, queue and output empty, registers at their defaults
`default_nettype none
module mono_glyph_blit_clipped_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [11:0]   cfg_data,
    input  wire logic          glyph_valid,
    output logic               glyph_stall,
    input  wire mgb_pkg::in_t  glyph_item,
    output logic               write_valid,
    input  wire logic          write_stall,
    output mgb_pkg::out_t      write_item
);

    mgb_pkg::cfg_t cfg_reg, cfg_next;
    mgb_pkg::cmd_t cmd;
    mgb_pkg::cmd_t q_head;
    logic          cmd_live;
    logic          accept;
    logic          q_full;
    logic          q_nonempty;
    logic          q_pop;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mgb_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                mgb_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                mgb_pkg::REG_GLYPH_COLS:   cfg_next.glyph_cols   = cfg_data[6:0];
                mgb_pkg::REG_GLYPH_ROWS:   cfg_next.glyph_rows   = cfg_data[6:0];
                mgb_pkg::REG_INK_WHITE:    cfg_next.ink_white    = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= mgb_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= mgb_pkg::RST_FRAME_HEIGHT;
            cfg_reg.glyph_cols   <= mgb_pkg::RST_GLYPH_COLS;
            cfg_reg.glyph_rows   <= mgb_pkg::RST_GLYPH_ROWS;
            cfg_reg.ink_white    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input handshake
    assign glyph_stall = q_full;
    assign accept      = glyph_valid && !q_full;

    mgb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .item     (glyph_item),
        .accept   (accept),
        .cmd      (cmd),
        .cmd_live (cmd_live)
    );

    mgb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept && cmd_live),
        .push_cmd (cmd),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    mgb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_nonempty  (q_nonempty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .write_valid (write_valid),
        .write_item  (write_item),
        .write_stall (write_stall)
    );

endmodule
`default_nettype wire
